// ===== design/bal_pkg.sv =====
package bal_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned LenW    = 5;
  localparam logic [DataW-1:0] EmptySlot = '1;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_LOCATE   = 3'd2,
    CMD_RETRIEVE = 3'd3,
    CMD_SORTED   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             commit;
    cmd_e             cmd;
    logic [DataW-1:0] val;
  } bcast_t;

endpackage

// ===== design/bounded_array_list_unit.sv =====
// Bounded array list: an ordered list of up to CAPACITY signed 32-bit values.
// Each input transfer carries a command, a value and a position; each one
// produces exactly one result transfer with a status, an answer and the
// list length after the command.
// Both channels use valid and stall. An input transfer happens on a rising
// edge with valid_i high and stall_o low; a result transfer happens with
// valid_o high and stall_i low.
// The list lives in a row of cells, one slot per cell. Every cell compares
// its entry with the broadcast value and takes its left or right neighbor,
// the new value, or keeps its entry, all in the same cycle.
// The output register loads the result on the edge of the input transfer,
// and the result can be taken on the next edge.
// Throughput is one item per cycle while the receiver does not stall, set by
// the cell row, which updates on the input edge, and the one-deep output register.
// While the receiver stalls a held result, stall_o is raised and no new
// command is taken; the held result stays unchanged.
// Reset sets every slot to minus one and the fill count to zero, and empties the
// output register; items are accepted from the first cycle after reset.
module bounded_array_list_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [2:0]                 command_i,
  input  logic signed [31:0]         data_value_i,
  input  logic [4:0]                 position_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [2:0]                 status_o,
  output logic signed [31:0]         answer_o,
  output logic [4:0]                 length_o
);
  import bal_pkg::*;

  // FW holds the fill count up to CAPACITY; CW is wide enough for both the
  // fill count and the 5-bit position so they compare without loss.
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > PosW) ? FW : PosW;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CapX = CW'(CAPACITY);

  logic [FW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    fill_x, fill_dx, pos_x;
  logic             in_fire;
  cmd_e             cmd;
  bcast_t           bcast;

  logic [DataW-1:0] slot   [CAPACITY];
  logic             run    [CAPACITY+1];
  logic             match  [CAPACITY];

  logic             full, empty;
  logic             found;
  logic [IW-1:0]    found_idx;

  status_e          status_d;
  logic [DataW-1:0] answer_d;
  logic             commit;

  logic             valid_q;
  status_e          status_q;
  logic [DataW-1:0] answer_q;
  logic [LenW-1:0]  length_q;

  // A new command is taken whenever the output register is free or is
  // being emptied in this same cycle.
  assign stall_o = valid_q && stall_i;
  assign in_fire = valid_i && !stall_o;
  assign cmd     = cmd_e'(command_i);

  assign fill_x  = CW'(fill_q);
  assign pos_x   = CW'(position_i);
  assign full    = fill_x >= CapX;
  assign empty   = fill_q == '0;

  // The tail end of the suffix chain: nothing beyond the last cell.
  assign run[CAPACITY] = 1'b1;

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DataW-1:0] left_w, right_w;
      logic             run_left_w;

      if (g == 0) begin : g_first
        assign left_w     = EmptySlot;
        assign run_left_w = 1'b0;
      end else begin : g_inner
        assign left_w     = slot[g-1];
        assign run_left_w = run[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_w = EmptySlot;
      end else begin : g_mid
        assign right_w = slot[g+1];
      end

      bal_cell #(
        .INDEX (g),
        .CW    (CW)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .bcast_i    (bcast),
        .fill_i     (fill_x),
        .pos_i      (pos_x),
        .left_i     (left_w),
        .right_i    (right_w),
        .run_left_i (run_left_w),
        .run_up_i   (run[g+1]),
        .run_o      (run[g]),
        .match_o    (match[g]),
        .slot_o     (slot[g])
      );
    end
  endgenerate

  // First matching cell wins; scan from the top so the lowest index sticks.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // Status, answer, next fill count and whether the cell row takes the command.
  always_comb begin
    status_d = ST_OK;
    answer_d = '0;
    commit   = 1'b0;
    fill_d   = fill_q;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_x > fill_x) begin
          status_d = ST_BADPOS;
          answer_d = EmptySlot;
        end else begin
          commit = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_x >= fill_x) begin
          status_d = ST_BADPOS;
          answer_d = EmptySlot;
        end else begin
          commit = 1'b1;
          fill_d = fill_q - FW'(1);
        end
      end
      CMD_LOCATE: begin
        if (found) begin
          answer_d = DataW'(found_idx);
        end else begin
          status_d = ST_NOTFOUND;
          answer_d = EmptySlot;
        end
      end
      CMD_RETRIEVE: begin
        if (pos_x >= fill_x) begin
          status_d = ST_BADPOS;
          answer_d = EmptySlot;
        end else begin
          answer_d = slot[pos_x[IW-1:0]];
        end
      end
      CMD_SORTED: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          commit = 1'b1;
          fill_d = fill_q + FW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign bcast.commit = commit && in_fire;
  assign bcast.cmd    = cmd;
  assign bcast.val    = data_value_i;

  assign fill_dx = CW'(fill_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        fill_q  <= fill_d;
        valid_q <= 1'b1;
      end else if (!stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      answer_q <= answer_d;
      length_q <= fill_dx[LenW-1:0];
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign answer_o = answer_q;
  assign length_o = length_q;

`ifndef NO_ASSERTIONS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_x <= CapX)
    else $error("fill count exceeds capacity");

  a_tail_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> slot[CAPACITY-1] == EmptySlot)
    else $error("top slot holds data while the list is not full");

  a_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcast.commit && (cmd == CMD_INSERT || cmd == CMD_SORTED)
    |=> fill_q == $past(fill_q) + FW'(1))
    else $error("insert did not grow the list by one");

  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> valid_o && length_o == $past(fill_dx[LenW-1:0]))
    else $error("accepted command did not produce its result");
`endif

endmodule

// ===== design/bal_cell.sv =====
module bal_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bal_pkg::bcast_t             bcast_i,
  input  logic [CW-1:0]               fill_i,
  input  logic [CW-1:0]               pos_i,
  input  logic [bal_pkg::DataW-1:0]   left_i,
  input  logic [bal_pkg::DataW-1:0]   right_i,
  input  logic                        run_left_i,
  input  logic                        run_up_i,
  output logic                        run_o,
  output logic                        match_o,
  output logic [bal_pkg::DataW-1:0]   slot_o
);
  import bal_pkg::*;

  localparam logic [CW-1:0] Idx = CW'(INDEX);

  logic [DataW-1:0] slot_q, slot_d;
  logic             above_fill;
  logic             greater;

  assign above_fill = Idx >= fill_i;
  assign greater    = $signed(slot_q) > $signed(bcast_i.val);
  // Every occupied entry from this cell to the tail is greater than the new value.
  assign run_o      = (above_fill || greater) && run_up_i;
  assign match_o    = !above_fill && (slot_q == bcast_i.val);
  assign slot_o     = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (bcast_i.commit) begin
      unique case (bcast_i.cmd)
        CMD_INSERT: begin
          if (Idx > pos_i) begin
            slot_d = left_i;
          end else if (Idx == pos_i) begin
            slot_d = bcast_i.val;
          end
        end
        CMD_DELETE: begin
          if (Idx >= pos_i) begin
            slot_d = right_i;
          end
        end
        CMD_SORTED: begin
          if (run_left_i) begin
            slot_d = left_i;
          end else if (run_o) begin
            slot_d = bcast_i.val;
          end
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= EmptySlot;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule
